// ===== rtl/p2l_pkg.sv =====
`timescale 1ns / 1ps

package p2l_pkg;

  // Row and palette sizing
  localparam int MAX_ROW_PIXELS = 4096;
  localparam int PAL_ENTRIES    = 256;
  localparam int PAL_AW         = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;
  localparam int PAL_W          = 32;
  localparam int LEN_W          = $clog2(MAX_ROW_PIXELS + 1);
  localparam int CNT_W          = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1;

  // Command queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Stream payload widths
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PIXEL_KIND  = 2'd0,
    CFG_SAMPLE_BITS = 2'd1,
    CFG_PAL_ALPHA   = 2'd2,
    CFG_ROW_PIXELS  = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    KIND_GRAY    = 3'd0,
    KIND_GRAY_A  = 3'd1,
    KIND_RGB     = 3'd2,
    KIND_RGB_A   = 3'd3,
    KIND_INDEX   = 3'd4
  } kind_e;

  typedef enum logic {
    OP_ROW_BYTE  = 1'b0,
    OP_PAL_WRITE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CMD_PAL_WR = 2'd0,
    CMD_PACKED = 2'd1,
    CMD_PIXEL  = 2'd2
  } cmd_e;

  // log2 of bits per packed sample: 1, 2, 4, 8 bits
  typedef enum logic [1:0] {
    BITS_1 = 2'd0,
    BITS_2 = 2'd1,
    BITS_4 = 2'd2,
    BITS_8 = 2'd3
  } bits_e;

  typedef struct packed {
    logic [2:0]            pixel_kind;
    logic [3:0]            sample_bits;
    logic                  pal_alpha_on;
    logic [CFG_DATA_W-1:0] row_pixels;
  } cfg_t;

  // One queued command. data is the row byte or the palette index.
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] data;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       use_alpha;
    logic       is_index;
    bits_e      bits_log;
  } q_item_t;

endpackage

// ===== rtl/p2l_ram.sv =====
`timescale 1ns / 1ps

module p2l_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/p2l_front.sv =====
`timescale 1ns / 1ps

module p2l_front
  import p2l_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 in_op_i,
  input  logic [S_TDATA_W-1:0] in_data_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output q_item_t              q_item_o
);

  logic [1:0]  phase_q, phase_d;
  logic [23:0] gath_q, gath_d;
  logic        acc;
  logic [7:0]  byte_in;
  bits_e       bits_log;

  assign in_ready_o = !q_full_i;
  assign acc        = in_valid_i && !q_full_i;
  assign byte_in    = in_data_i[7:0];

  always_comb begin
    case (cfg_i.sample_bits)
      4'd1:    bits_log = BITS_1;
      4'd2:    bits_log = BITS_2;
      4'd4:    bits_log = BITS_4;
      default: bits_log = BITS_8;
    endcase
  end

  always_comb begin
    phase_d            = phase_q;
    gath_d             = gath_q;
    q_push_o           = 1'b0;
    q_item_o           = '0;
    q_item_o.cmd       = CMD_PIXEL;
    q_item_o.bits_log  = bits_log;
    q_item_o.data      = byte_in;
    if (acc) begin
      if (op_e'(in_op_i) == OP_PAL_WRITE) begin
        q_push_o       = 1'b1;
        q_item_o.cmd   = CMD_PAL_WR;
        q_item_o.data  = in_data_i[15:8];
        q_item_o.red   = in_data_i[23:16];
        q_item_o.green = in_data_i[31:24];
        q_item_o.blue  = in_data_i[39:32];
        q_item_o.alpha = in_data_i[47:40];
      end else begin
        case (kind_e'(cfg_i.pixel_kind))
          KIND_GRAY, KIND_INDEX: begin
            q_push_o          = 1'b1;
            q_item_o.cmd      = CMD_PACKED;
            q_item_o.is_index = (kind_e'(cfg_i.pixel_kind) == KIND_INDEX);
            phase_d           = '0;
            gath_d            = '0;
          end
          KIND_GRAY_A, KIND_RGB, KIND_RGB_A: begin
            // pixel complete once phase + 1 reaches kind + 1 bytes
            if ({1'b0, phase_q} >= cfg_i.pixel_kind) begin
              q_push_o = 1'b1;
              phase_d  = '0;
              gath_d   = '0;
              case (kind_e'(cfg_i.pixel_kind))
                KIND_GRAY_A: begin
                  // the weights sum to 256, so luma of v,v,v is v
                  q_item_o.red       = gath_q[7:0];
                  q_item_o.green     = gath_q[7:0];
                  q_item_o.blue      = gath_q[7:0];
                  q_item_o.alpha     = byte_in;
                  q_item_o.use_alpha = 1'b1;
                end
                KIND_RGB: begin
                  q_item_o.red   = gath_q[15:8];
                  q_item_o.green = gath_q[7:0];
                  q_item_o.blue  = byte_in;
                end
                default: begin
                  q_item_o.red       = gath_q[23:16];
                  q_item_o.green     = gath_q[15:8];
                  q_item_o.blue      = gath_q[7:0];
                  q_item_o.alpha     = byte_in;
                  q_item_o.use_alpha = 1'b1;
                end
              endcase
            end else begin
              gath_d  = {gath_q[15:0], byte_in};
              phase_d = phase_q + 2'd1;
            end
          end
          default: begin
            // unknown kind: byte dropped
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      gath_q  <= '0;
    end else begin
      phase_q <= phase_d;
      gath_q  <= gath_d;
    end
  end

endmodule

// ===== rtl/p2l_queue.sv =====
`timescale 1ns / 1ps

module p2l_queue
  import p2l_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  q_item_t item_i,
  output logic    full_o,
  output logic    head_valid_o,
  output q_item_t head_o,
  input  logic    pop_i
);

  q_item_t       mem_q [Q_DEPTH];
  logic [Q_AW:0] wptr_q, rptr_q;

  assign head_valid_o = (wptr_q != rptr_q);
  assign full_o       = (wptr_q[Q_AW] != rptr_q[Q_AW]) &&
                        (wptr_q[Q_AW-1:0] == rptr_q[Q_AW-1:0]);
  assign head_o       = mem_q[rptr_q[Q_AW-1:0]];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wptr_q[Q_AW-1:0]] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      if (push_i && !full_o) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i && head_valid_o) begin
        rptr_q <= rptr_q + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/p2l_back.sv =====
`timescale 1ns / 1ps

module p2l_back
  import p2l_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       head_valid_i,
  input  q_item_t    head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_luma_o,
  output logic       out_row_end_o,
  output logic       out_last_o
);

  // whole pipe moves together when the output slot frees up
  logic adv;

  // issue stage
  logic [2:0]       samp_i_q;
  logic [CNT_W-1:0] cnt_q;
  logic [LEN_W-1:0] len;
  logic [31:0]      cnt_nx;
  logic             rend, last_samp, fire, pal_we, pal_ok;
  logic [7:0]       sh8, samp, gray;
  logic [5:0]       sh_amt;
  logic [PAL_W-1:0] rdata;

  // stage 1: palette read data lines up with these
  logic       s1_v_q, s1_ram_q, s1_hit_q, s1_alpha_q, s1_rend_q, s1_last_q;
  logic [7:0] s1_r_q, s1_g_q, s1_b_q, s1_a_q;
  logic [7:0] c_r, c_g, c_b, c_a;

  // stage 2: weighted products
  logic        s2_v_q, s2_alpha_q, s2_rend_q, s2_last_q;
  logic [14:0] s2_pr_q;
  logic [15:0] s2_pg_q;
  logic [12:0] s2_pb_q;
  logic [7:0]  s2_a_q;
  logic [15:0] sum;
  logic [7:0]  y;
  logic [16:0] mix;

  // stage 3: blended numerator
  logic        s3_v_q, s3_alpha_q, s3_rend_q, s3_last_q;
  logic [15:0] s3_x_q;
  logic [25:0] dq;

  // output register
  logic       out_v_q, out_rend_q, out_last_q;
  logic [7:0] out_luma_q;

  assign adv = !out_v_q || out_ready_i;

  always_comb begin
    if (cfg_i.row_pixels == '0) begin
      len = LEN_W'(1);
    end else if (32'(cfg_i.row_pixels) > 32'(MAX_ROW_PIXELS)) begin
      len = LEN_W'(MAX_ROW_PIXELS);
    end else begin
      len = LEN_W'(cfg_i.row_pixels);
    end
  end

  assign cnt_nx = 32'(cnt_q) + 32'd1;
  assign rend   = (cnt_nx >= 32'(len));

  // MSB-first sample pick
  assign sh_amt = 6'(samp_i_q) << head_i.bits_log;
  assign sh8    = head_i.data << sh_amt;

  always_comb begin
    case (head_i.bits_log)
      BITS_1: begin
        samp = {7'b0, sh8[7]};
        gray = {8{sh8[7]}};
      end
      BITS_2: begin
        samp = {6'b0, sh8[7:6]};
        gray = {4{sh8[7:6]}};
      end
      BITS_4: begin
        samp = {4'b0, sh8[7:4]};
        gray = {2{sh8[7:4]}};
      end
      default: begin
        samp = sh8;
        gray = sh8;
      end
    endcase
  end

  assign last_samp = (samp_i_q == 3'((4'd8 >> head_i.bits_log) - 4'd1));
  assign fire      = adv && head_valid_i && (head_i.cmd != CMD_PAL_WR);
  assign pal_ok    = ({1'b0, head_i.data} < 9'(PAL_ENTRIES));
  assign pal_we    = adv && head_valid_i && (head_i.cmd == CMD_PAL_WR) && pal_ok;
  assign pop_o     = adv && head_valid_i &&
                     ((head_i.cmd != CMD_PACKED) || rend || last_samp);

  p2l_ram #(
    .Width (PAL_W),
    .Depth (PAL_ENTRIES)
  ) u_pal_ram (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (head_i.data[PAL_AW-1:0]),
    .wdata_i ({head_i.red, head_i.green, head_i.blue, head_i.alpha}),
    .re_i    (adv),
    .raddr_i (samp[PAL_AW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samp_i_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (adv && head_valid_i && (head_i.cmd == CMD_PACKED)) begin
        samp_i_q <= pop_o ? 3'd0 : samp_i_q + 3'd1;
      end
      if (fire) begin
        cnt_q <= rend ? '0 : CNT_W'(cnt_nx);
      end
    end
  end

  // stage 1 payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ram_q  <= (head_i.cmd == CMD_PACKED) && head_i.is_index;
      s1_hit_q  <= ({1'b0, samp} < 9'(PAL_ENTRIES));
      s1_rend_q <= rend;
      s1_last_q <= (head_i.cmd != CMD_PACKED) || rend || last_samp;
      if (head_i.cmd == CMD_PACKED) begin
        s1_r_q     <= gray;
        s1_g_q     <= gray;
        s1_b_q     <= gray;
        s1_a_q     <= '0;
        s1_alpha_q <= head_i.is_index && cfg_i.pal_alpha_on;
      end else begin
        s1_r_q     <= head_i.red;
        s1_g_q     <= head_i.green;
        s1_b_q     <= head_i.blue;
        s1_a_q     <= head_i.alpha;
        s1_alpha_q <= head_i.use_alpha;
      end
    end
  end

  always_comb begin
    if (s1_ram_q) begin
      if (s1_hit_q) begin
        {c_r, c_g, c_b, c_a} = rdata;
      end else begin
        {c_r, c_g, c_b, c_a} = '0;
      end
    end else begin
      c_r = s1_r_q;
      c_g = s1_g_q;
      c_b = s1_b_q;
      c_a = s1_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_pr_q    <= 15'(c_r) * 15'd77;
      s2_pg_q    <= 16'(c_g) * 16'd150;
      s2_pb_q    <= 13'(c_b) * 13'd29;
      s2_a_q     <= c_a;
      s2_alpha_q <= s1_alpha_q;
      s2_rend_q  <= s1_rend_q;
      s2_last_q  <= s1_last_q;
    end
  end

  // luma and over-white numerator: y*a + 255*(255-a)
  assign sum = 16'(s2_pr_q) + s2_pg_q + 16'(s2_pb_q);
  assign y   = sum[15:8];
  assign mix = 17'(y) * 17'(s2_a_q) + 17'({8'hFF - s2_a_q, 8'h00}) - 17'(8'hFF - s2_a_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_x_q     <= s2_alpha_q ? mix[15:0] : {8'h00, y};
      s3_alpha_q <= s2_alpha_q;
      s3_rend_q  <= s2_rend_q;
      s3_last_q  <= s2_last_q;
    end
  end

  // exact x / 255 for x <= 255*255: ((x + 1) * 257) >> 16
  assign dq = (26'(s3_x_q) + 26'd1) * 26'd257;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_luma_q <= s3_alpha_q ? dq[23:16] : s3_x_q[7:0];
      out_rend_q <= s3_rend_q;
      out_last_q <= s3_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q  <= fire;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      out_v_q <= s3_v_q;
    end
  end

  assign out_valid_o   = out_v_q;
  assign out_luma_o    = out_luma_q;
  assign out_row_end_o = out_rend_q;
  assign out_last_o    = out_last_q;

endmodule

// ===== rtl/png_row_to_luma.sv =====
`timescale 1ns / 1ps

// PNG row bytes in, 8-bit luma pixels out.
// Slave channel: one beat per row byte (tuser = 0) or palette entry write
// (tuser = 1). Master channel: one beat per pixel, tlast on the last pixel
// of a row, tuser on the last pixel made from one input beat.
// Config: write cfg_we_i/cfg_idx_i/cfg_wdata_i only while the block is idle.
//   0 pixel kind, 1 sample bits, 2 palette alpha enable, 3 row pixels.
// Front end gathers multi-byte pixels and pushes commands into a 4-deep
// queue; back end issues one pixel per cycle, unless stalled, into a 4-stage pipe
// (palette read, weighting, over-white blend, divide by 255).
// Throughput: one pixel per cycle unless stalled, set by the back-end issue
// stage; a packed byte gives 8/sample_bits pixels (1 to 8), fewer at a row
// end; palette writes and final bytes of multi-byte pixels also pass the issue
// stage, and gathering bytes never reach the back end.
// Reset: clears config to defaults, row and gather state, queue and pipe;
// palette contents stay undefined until written.
// Stall: a low m_axis_tready with a beat waiting freezes the pipe; the queue
// keeps taking beats until full, then s_axis_tready drops.
module png_row_to_luma
  import p2l_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [7:0] data_byte, [15:8] pal_index, [23:16] pal_red,
  // [31:24] pal_green, [39:32] pal_blue, [47:40] pal_alpha
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,
  // [0] op
  input  logic                  s_axis_tuser,
  // output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [7:0] luma
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  output logic                  m_axis_tlast,
  // [0] last
  output logic                  m_axis_tuser
);

  cfg_t    cfg_q;
  logic    q_push, q_full, q_hv, q_pop;
  q_item_t q_in, q_head;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_kind   <= KIND_GRAY;
      cfg_q.sample_bits  <= 4'd8;
      cfg_q.pal_alpha_on <= 1'b0;
      cfg_q.row_pixels   <= CFG_DATA_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PIXEL_KIND:  cfg_q.pixel_kind   <= cfg_wdata_i[2:0];
        CFG_SAMPLE_BITS: cfg_q.sample_bits  <= cfg_wdata_i[3:0];
        CFG_PAL_ALPHA:   cfg_q.pal_alpha_on <= cfg_wdata_i[0];
        CFG_ROW_PIXELS:  cfg_q.row_pixels   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  p2l_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_op_i    (s_axis_tuser),
    .in_data_i  (s_axis_tdata),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (q_in)
  );

  p2l_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .item_i       (q_in),
    .full_o       (q_full),
    .head_valid_o (q_hv),
    .head_o       (q_head),
    .pop_i        (q_pop)
  );

  p2l_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .head_valid_i  (q_hv),
    .head_i        (q_head),
    .pop_o         (q_pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_luma_o    (m_axis_tdata),
    .out_row_end_o (m_axis_tlast),
    .out_last_o    (m_axis_tuser)
  );

endmodule

// ===== rtl/p2l_checker.sv =====
`timescale 1ns / 1ps

module p2l_checker
  import p2l_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic                 m_axis_tlast,
  input logic                 m_axis_tuser
);

  // a pixel that ends a row always closes the burst of its input beat
  a_row_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("row end without last flag");

  // reset empties the output slot
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("output valid during reset");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped under stall");

  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("output beat changed under stall");

endmodule

bind png_row_to_luma p2l_checker u_p2l_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
